>>> src/tdpf_pkg.sv
// Package with the types, constants and codes of the threshold-drain packet FIFO.
`default_nettype none
package tdpf_pkg;

   localparam int DEPTH     = 1024;
   localparam int MAX_BURST = 32;

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int FILL_W  = $clog2(DEPTH + 1);
   localparam int OCC_W   = 11;
   localparam int MARK_W  = 11;
   localparam int BURST_W = 6;
   localparam int CMP_W   = (FILL_W > MARK_W) ? FILL_W : MARK_W;
   localparam int CNT_W   = 32;
   localparam int HNDL_W  = 32;
   localparam int LEN_W   = 16;
   localparam int ENTRY_W = HNDL_W + LEN_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [BURST_W-1:0] BURST_RESET     = BURST_W'(32);
   localparam logic [MARK_W-1:0]  HIGH_MARK_RESET = MARK_W'(1024);
   localparam logic [MARK_W-1:0]  LOW_MARK_RESET  = MARK_W'(0);
   localparam logic [MARK_W-1:0]  THRESH_RESET    = MARK_W'(100);
   localparam logic [CNT_W-1:0]   CNT_MAX         = {CNT_W{1'b1}};

   typedef enum logic {
      KIND_ENQUEUE = 1'b0,
      KIND_DEQUEUE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      RK_ENQUEUED   = 2'd0,
      RK_DROPPED    = 2'd1,
      RK_PACKET_OUT = 2'd2,
      RK_NOTHING    = 2'd3
   } rsp_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BURST_SIZE  = 3'd0,
      CSR_BP_ENABLE   = 3'd1,
      CSR_HIGH_MARK   = 3'd2,
      CSR_LOW_MARK    = 3'd3,
      CSR_START_THR   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   // Input word, packet_handle in the lowest bits.
   typedef struct packed {
      logic [6:0]        pad;
      logic              downstream_overloaded;
      logic [LEN_W-1:0]  packet_length;
      logic [HNDL_W-1:0] packet_handle;
   } req_data_type;

   // Result word, out_handle in the lowest bits.
   typedef struct packed {
      logic [1:0]        pad;
      logic [CNT_W-1:0]  dropped_total;
      logic [CNT_W-1:0]  dequeued_total;
      logic [CNT_W-1:0]  enqueued_total;
      logic [OCC_W-1:0]  occupancy;
      logic              blocked;
      logic              underload;
      logic              overload;
      logic [LEN_W-1:0]  out_length;
      logic [HNDL_W-1:0] out_handle;
   } rsp_data_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

endpackage
`default_nettype wire

>>> src/tdpf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module tdpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> src/threshold_drain_packet_fifo.sv
// Packet descriptor FIFO with a start-threshold send gate and watermark signalling.
// Enqueue words and dequeue words that emit nothing give their result in the cycle after
// acceptance and a new word is taken every cycle while the result side keeps up.
// A dequeue burst of n packets emits each packet in two steps (store read, then output
// register load, which waits while the result side stalls) and the next word is taken after the last packet is loaded.
// Synchronous reset clears pointers, counters and the gate and restores the register
// defaults; the descriptor store is not cleared, as only filled entries are ever read.
`default_nettype none
module threshold_drain_packet_fifo (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // packet_handle, packet_length, downstream_overloaded, zero fill
   input  wire logic [55:0]                         req_tdata,
   // kind
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // out_handle, out_length, overload, underload, blocked, occupancy,
   // enqueued_total, dequeued_total, dropped_total, zero fill
   output logic [159:0]                             rsp_tdata,
   // result_kind
   output logic [1:0]                               rsp_tuser,
   output logic                                     rsp_tlast,
   input  wire logic                                csr_wr_en,
   input  wire logic [tdpf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tdpf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tdpf_pkg::*;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               gate_ff, gate_in;
   logic [CNT_W-1:0]   enq_cnt_ff, enq_cnt_in;
   logic [CNT_W-1:0]   deq_cnt_ff, deq_cnt_in;
   logic [CNT_W-1:0]   drop_cnt_ff, drop_cnt_in;
   logic [BURST_W-1:0] remain_ff, remain_in;

   logic [BURST_W-1:0] burst_ff;
   logic               bp_en_ff;
   logic [MARK_W-1:0]  high_mark_ff;
   logic [MARK_W-1:0]  low_mark_ff;
   logic [MARK_W-1:0]  start_thr_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff, rsp_data_in;
   rsp_kind_type       rsp_kind_ff, rsp_kind_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               ram_we;
   logic               ram_re;
   logic [ENTRY_W-1:0] ram_rdata;

   req_data_type       req_data;
   logic               out_free;
   logic [BURST_W-1:0] burst_csr;

   assign req_data  = req_data_type'(req_tdata);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign burst_csr = csr_wdata[BURST_W-1:0];

   tdpf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data ({req_data.packet_length, req_data.packet_handle}),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff     <= BURST_RESET;
         bp_en_ff     <= 1'b0;
         high_mark_ff <= HIGH_MARK_RESET;
         low_mark_ff  <= LOW_MARK_RESET;
         start_thr_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BURST_SIZE: begin
               if (BURST_W'(burst_csr) <= BURST_W'(MAX_BURST)) begin
                  burst_ff <= burst_csr;
               end
            end
            CSR_BP_ENABLE: bp_en_ff     <= csr_wdata[0];
            CSR_HIGH_MARK: high_mark_ff <= csr_wdata[MARK_W-1:0];
            CSR_LOW_MARK:  low_mark_ff  <= csr_wdata[MARK_W-1:0];
            CSR_START_THR: start_thr_ff <= csr_wdata[MARK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         gate_ff      <= 1'b0;
         enq_cnt_ff   <= '0;
         deq_cnt_ff   <= '0;
         drop_cnt_ff  <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         gate_ff      <= gate_in;
         enq_cnt_ff   <= enq_cnt_in;
         deq_cnt_ff   <= deq_cnt_in;
         drop_cnt_ff  <= drop_cnt_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      logic [FILL_W-1:0]  fill_new;
      logic [CMP_W-1:0]   burst_ext;
      logic [BURST_W-1:0] take;
      logic               fin;

      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      gate_in      = gate_ff;
      enq_cnt_in   = enq_cnt_ff;
      deq_cnt_in   = deq_cnt_ff;
      drop_cnt_in  = drop_cnt_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      req_tready   = 1'b0;
      fill_new     = fill_ff;
      burst_ext    = CMP_W'(burst_ff);
      take         = '0;
      fin          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = out_free;
            if (req_tvalid && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_data_in  = '0;
               if (req_kind_type'(req_tuser) == KIND_ENQUEUE) begin
                  if (fill_ff == FILL_W'(DEPTH)) begin
                     drop_cnt_in = sat_inc(drop_cnt_ff);
                     rsp_kind_in = RK_DROPPED;
                  end else begin
                     ram_we      = 1'b1;
                     tail_in     = ptr_next(tail_ff);
                     fill_new    = fill_ff + FILL_W'(1);
                     enq_cnt_in  = sat_inc(enq_cnt_ff);
                     rsp_kind_in = RK_ENQUEUED;
                  end
                  fill_in = fill_new;
                  rsp_data_in.overload =
                     bp_en_ff && (CMP_W'(fill_new) > CMP_W'(high_mark_ff));
                  if (CMP_W'(fill_new) >= CMP_W'(start_thr_ff)) begin
                     gate_in = 1'b1;
                  end
               end else begin
                  rsp_kind_in = RK_NOTHING;
                  if (burst_ext > CMP_W'(fill_ff)) begin
                     take = BURST_W'(fill_ff);
                  end else begin
                     take = burst_ff;
                  end
                  priority if (req_data.downstream_overloaded) begin
                     rsp_data_in.blocked = 1'b1;
                  end else if (!gate_ff) begin
                     rsp_data_in.blocked = 1'b0;
                  end else if (take == '0) begin
                     rsp_data_in.blocked = 1'b1;
                  end else begin
                     rsp_valid_in = rsp_valid_ff && !rsp_tready;
                     rsp_data_in  = rsp_data_ff;
                     rsp_kind_in  = rsp_kind_ff;
                     rsp_last_in  = rsp_last_ff;
                     remain_in    = take;
                     state_in     = ST_READ;
                  end
               end
               if (state_in == ST_IDLE) begin
                  rsp_data_in.occupancy      = OCC_W'(fill_in);
                  rsp_data_in.enqueued_total = enq_cnt_in;
                  rsp_data_in.dequeued_total = deq_cnt_in;
                  rsp_data_in.dropped_total  = drop_cnt_in;
               end
            end
         end

         ST_READ: begin
            ram_re     = 1'b1;
            head_in    = ptr_next(head_ff);
            fill_in    = fill_ff - FILL_W'(1);
            deq_cnt_in = sat_inc(deq_cnt_ff);
            remain_in  = remain_ff - BURST_W'(1);
            state_in   = ST_EMIT;
         end

         ST_EMIT: begin
            if (out_free) begin
               fin                        = (remain_ff == '0);
               rsp_valid_in               = 1'b1;
               rsp_kind_in                = RK_PACKET_OUT;
               rsp_last_in                = fin;
               rsp_data_in                = '0;
               rsp_data_in.out_handle     = ram_rdata[HNDL_W-1:0];
               rsp_data_in.out_length     = ram_rdata[ENTRY_W-1:HNDL_W];
               rsp_data_in.underload      =
                  fin && bp_en_ff && (CMP_W'(fill_ff) < CMP_W'(low_mark_ff));
               rsp_data_in.occupancy      = OCC_W'(fill_ff);
               rsp_data_in.enqueued_total = enq_cnt_ff;
               rsp_data_in.dequeued_total = deq_cnt_ff;
               rsp_data_in.dropped_total  = drop_cnt_ff;
               if (fin) begin
                  if (fill_ff == '0) begin
                     gate_in = 1'b0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the threshold-drain packet descriptor FIFO.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tdpf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef struct {
      rsp_kind_type kind;
      logic         last;
      rsp_data_type data;
   } fifo_result_type;

   class descriptor_fifo_scoreboard;
      logic [ENTRY_W-1:0] slots [DEPTH];
      logic [PTR_W-1:0]   rd_ptr;
      logic [PTR_W-1:0]   wr_ptr;
      logic [OCC_W-1:0]   fill;
      logic               gate_open;
      logic [CNT_W-1:0]   n_accepted;
      logic [CNT_W-1:0]   n_emitted;
      logic [CNT_W-1:0]   n_dropped;
      logic [BURST_W-1:0] burst;
      logic               bp_on;
      logic [MARK_W-1:0]  high_mark;
      logic [MARK_W-1:0]  low_mark;
      logic [MARK_W-1:0]  start_thr;
      fifo_result_type    pending_results [$];
      int                 errors;

      function new();
         rd_ptr     = '0;
         wr_ptr     = '0;
         fill       = '0;
         gate_open  = 1'b0;
         n_accepted = '0;
         n_emitted  = '0;
         n_dropped  = '0;
         burst      = BURST_W'(32);
         bp_on      = 1'b0;
         high_mark  = MARK_W'(1024);
         low_mark   = '0;
         start_thr  = MARK_W'(100);
         errors     = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_BURST_SIZE: begin
               if (value[BURST_W-1:0] <= MAX_BURST) burst = value[BURST_W-1:0];
            end
            CSR_BP_ENABLE: bp_on = value[0];
            CSR_HIGH_MARK: high_mark = value;
            CSR_LOW_MARK:  low_mark = value;
            CSR_START_THR: start_thr = value;
            default: ;
         endcase
      endfunction

      function void push_result(rsp_kind_type kind, logic [ENTRY_W-1:0] entry,
                                logic ovl, logic unl, logic blk, logic last);
         fifo_result_type r;
         r.kind                = kind;
         r.last                = last;
         r.data                = '0;
         r.data.out_handle     = entry[HNDL_W-1:0];
         r.data.out_length     = entry[ENTRY_W-1:HNDL_W];
         r.data.overload       = ovl;
         r.data.underload      = unl;
         r.data.blocked        = blk;
         r.data.occupancy      = fill;
         r.data.enqueued_total = n_accepted;
         r.data.dequeued_total = n_emitted;
         r.data.dropped_total  = n_dropped;
         pending_results.push_back(r);
      endfunction

      function void note_word(req_kind_type kind, logic [HNDL_W-1:0] handle,
                              logic [LEN_W-1:0] length, logic down);
         rsp_kind_type rk;
         int           n;
         logic         unl;
         logic         fin;
         logic [ENTRY_W-1:0] entry;
         if (kind == KIND_ENQUEUE) begin
            if (fill >= DEPTH) begin
               if (n_dropped != '1) n_dropped++;
               rk = RK_DROPPED;
            end else begin
               slots[wr_ptr] = {length, handle};
               wr_ptr = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
               fill++;
               if (n_accepted != '1) n_accepted++;
               rk = RK_ENQUEUED;
            end
            if (fill >= start_thr) gate_open = 1'b1;
            push_result(rk, '0, bp_on && (fill > high_mark), 1'b0, 1'b0, 1'b1);
         end else if (down) begin
            push_result(RK_NOTHING, '0, 1'b0, 1'b0, 1'b1, 1'b1);
         end else if (!gate_open) begin
            push_result(RK_NOTHING, '0, 1'b0, 1'b0, 1'b0, 1'b1);
         end else begin
            n = (int'(burst) > int'(fill)) ? int'(fill) : int'(burst);
            if (n == 0) begin
               push_result(RK_NOTHING, '0, 1'b0, 1'b0, 1'b1, 1'b1);
            end
            for (int i = 0; i < n; i++) begin
               entry = slots[rd_ptr];
               rd_ptr = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
               fill--;
               if (n_emitted != '1) n_emitted++;
               fin = (i == n - 1);
               unl = 1'b0;
               if (fin) begin
                  if (fill == 0) gate_open = 1'b0;
                  unl = bp_on && (fill < low_mark);
               end
               push_result(RK_PACKET_OUT, entry, 1'b0, unl, 1'b0, fin);
            end
         end
      endfunction

      function void compare(string name, logic [31:0] expv, logic [31:0] actv);
         if (expv !== actv) begin
            $error("%s: expected %0h, got %0h", name, expv, actv);
            errors++;
         end
      endfunction

      function void check_result(rsp_kind_type kind, logic last, rsp_data_type d);
         fifo_result_type e;
         if (pending_results.size() == 0) begin
            $error("result word arrived with nothing outstanding");
            errors++;
            return;
         end
         e = pending_results.pop_front();
         compare("result_kind", 32'(e.kind), 32'(kind));
         compare("out_handle", e.data.out_handle, d.out_handle);
         compare("out_length", 32'(e.data.out_length), 32'(d.out_length));
         compare("overload", 32'(e.data.overload), 32'(d.overload));
         compare("underload", 32'(e.data.underload), 32'(d.underload));
         compare("blocked", 32'(e.data.blocked), 32'(d.blocked));
         compare("last", 32'(e.last), 32'(last));
         compare("occupancy", 32'(e.data.occupancy), 32'(d.occupancy));
         compare("enqueued_total", e.data.enqueued_total, d.enqueued_total);
         compare("dequeued_total", e.data.dequeued_total, d.dequeued_total);
         compare("dropped_total", e.data.dropped_total, d.dropped_total);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [55:0]           req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [159:0]          rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   descriptor_fifo_scoreboard sb;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   threshold_drain_packet_fifo u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_kind_type'(rsp_tuser), rsp_tlast, rsp_data_type'(rsp_tdata));
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_word(req_kind_type kind, logic [HNDL_W-1:0] handle,
                            logic [LEN_W-1:0] length, logic down);
      req_data_type w;
      w = '0;
      w.packet_handle = handle;
      w.packet_length = length;
      w.downstream_overloaded = down;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      sb.note_word(kind, handle, length, down);
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic configure(int burst, int bp, int high, int low, int thr);
      write_reg(CSR_BURST_SIZE, CSR_DATA_W'(burst));
      write_reg(CSR_BP_ENABLE, CSR_DATA_W'(bp));
      write_reg(CSR_HIGH_MARK, CSR_DATA_W'(high));
      write_reg(CSR_LOW_MARK, CSR_DATA_W'(low));
      write_reg(CSR_START_THR, CSR_DATA_W'(thr));
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_words(int count);
      logic [LEN_W-1:0] length;
      int               pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(7);
         length = (pick == 0) ? '0 : (pick == 1) ? '1 : LEN_W'($urandom);
         if ($urandom_range(99) < 55) begin
            send_word(KIND_ENQUEUE, $urandom, length, 1'($urandom));
         end else begin
            send_word(KIND_DEQUEUE, $urandom, length, $urandom_range(99) < 15);
         end
      end
      drain_and_settle();
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(KIND_DEQUEUE, '0, '0, 1'b0);
      send_word(KIND_DEQUEUE, '1, '1, 1'b1);
      send_word(KIND_ENQUEUE, '0, '0, 1'b0);
      send_word(KIND_ENQUEUE, '1, '1, 1'b1);
      drain_and_settle();

      configure(2, 1, 0, 1024, 1);
      send_word(KIND_ENQUEUE, 32'hAAAA_AAAA, 16'h5555, 1'b0);
      send_word(KIND_DEQUEUE, '0, '0, 1'b1);
      send_word(KIND_DEQUEUE, '0, '0, 1'b0);
      send_word(KIND_DEQUEUE, '1, '1, 1'b0);
      send_word(KIND_DEQUEUE, '0, '0, 1'b0);
      send_word(KIND_ENQUEUE, 32'h5555_5555, 16'hAAAA, 1'b1);
      send_word(KIND_ENQUEUE, 32'h1234_5678, 16'h00FF, 1'b0);
      drain_and_settle();

      write_reg(CSR_BURST_SIZE, '0);
      write_reg(CSR_BURST_SIZE, CSR_DATA_W'(33));
      csr_wr_en <= 1'b0;
      send_word(KIND_DEQUEUE, '0, '0, 1'b0);
      drain_and_settle();

      configure(8, 1, 10, 1024, 16);
      for (int i = 0; i < 24; i++) begin
         send_word(KIND_ENQUEUE, $urandom, LEN_W'($urandom), 1'($urandom));
      end
      while (sb.fill != 0) begin
         send_word(KIND_DEQUEUE, $urandom, LEN_W'($urandom), $urandom_range(99) < 10);
      end
      drain_and_settle();

      send_idle_pct = 63;
      configure($urandom_range(1, 6), 1, $urandom_range(0, 12),
                $urandom_range(0, 12), $urandom_range(1, 10));
      random_words(30);

      send_idle_pct = 0;
      recv_stall_pct = 63;
      configure($urandom_range(0, 8), $urandom_range(0, 1), $urandom_range(0, 12),
                $urandom_range(0, 12), $urandom_range(1, 10));
      random_words(30);

      send_idle_pct = 34;
      recv_stall_pct = 34;
      configure($urandom_range(1, 8), 1, $urandom_range(0, 12),
                $urandom_range(0, 12), $urandom_range(1, 10));
      random_words(30);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_reg(CSR_BURST_SIZE, CSR_DATA_W'(32));
      write_reg(CSR_BP_ENABLE, CSR_DATA_W'(1));
      write_reg(CSR_HIGH_MARK, CSR_DATA_W'(1024));
      write_reg(CSR_LOW_MARK, CSR_DATA_W'(0));
      write_reg(CSR_START_THR, CSR_DATA_W'(0));
      write_reg(CSR_BURST_SIZE, '1);
      write_reg(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
      random_words(20);

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
